### rtl/kps_pkg.sv
// kps_pkg: shared types, constants and per-key update functions for the keypad scanner
// used by kps_delay_norm, kps_key_array and matrix_keypad_scanner_unit
package kps_pkg;

    localparam int ROWS            = 4;
    localparam int COLUMNS         = 4;
    localparam int DEBOUNCE_VISITS = 5;
    localparam int NKEYS           = ROWS * COLUMNS;
    localparam int SENSE_BITS      = 4;
    localparam int DELAY_W         = 16;
    localparam int SAMPLE_W        = 5;
    localparam int ROW_W           = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int STEP_W          = $clog2(DELAY_W);

    localparam logic [SAMPLE_W-1:0] PRESS_AT   = SAMPLE_W'(DEBOUNCE_VISITS);
    localparam logic [SAMPLE_W-1:0] RELEASE_AT = SAMPLE_W'(-DEBOUNCE_VISITS);

    localparam logic [DELAY_W-1:0] HOLD_VISITS_RESET   = DELAY_W'(125);
    localparam logic [DELAY_W-1:0] REPEAT_VISITS_RESET = DELAY_W'(25);

    localparam logic FUNC_SCAN  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic [1:0] REG_HOLD_VISITS   = 2'd0;
    localparam logic [1:0] REG_REPEAT_VISITS = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LEVEL  = 2'd2;

    typedef struct packed {
        logic       func;
        logic [3:0] column_sense;
        logic [1:0] key_row;
        logic [1:0] key_col;
    } kps_in_t;

    typedef struct packed {
        logic [1:0] scanned_row;
        logic [3:0] pressed_mask;
        logic       key_pressed;
        logic       key_typed;
    } kps_out_t;

    typedef struct packed {
        logic [DELAY_W-1:0] hold_visits;
        logic [DELAY_W-1:0] repeat_visits;
        logic               active_level;
    } kps_cfg_t;

    typedef struct packed {
        logic busy;
        logic finish;
    } kps_norm_stat_t;

    // phase is the delay count reduced below the current limit
    typedef struct packed {
        logic [SAMPLE_W-1:0] samples;
        logic                pressed;
        logic                hold;
        logic [DELAY_W-1:0]  delay;
        logic [DELAY_W-1:0]  phase;
        logic                typed;
    } key_state_t;

    // zero stands for a full 16 bit period
    function automatic logic [DELAY_W:0] limit_ext(logic [DELAY_W-1:0] limit);
        logic [DELAY_W:0] ext;
        ext = (limit == '0) ? {1'b1, {DELAY_W{1'b0}}} : {1'b0, limit};
        return ext;
    endfunction

    // count is kept below its limit, so a wrap is a single compare
    function automatic logic [DELAY_W-1:0] delay_step(logic [DELAY_W-1:0] count,
                                                      logic [DELAY_W-1:0] limit);
        logic [DELAY_W:0] nxt;
        nxt = {1'b0, count} + (DELAY_W + 1)'(1);
        return (nxt == limit_ext(limit)) ? '0 : nxt[DELAY_W-1:0];
    endfunction

    function automatic key_state_t key_step(key_state_t st, logic closed,
                                            logic [DELAY_W-1:0] hold_lim,
                                            logic [DELAY_W-1:0] rep_lim);
        key_state_t          nx;
        logic [SAMPLE_W-1:0] inc;
        logic [SAMPLE_W-1:0] dec;
        logic [DELAY_W-1:0]  dly;
        nx  = st;
        inc = st.samples + SAMPLE_W'(1);
        dec = st.samples - SAMPLE_W'(1);
        dly = '0;
        if (closed)
        begin
            if (!st.pressed)
            begin
                if (inc == PRESS_AT)
                begin
                    nx.samples = '0;
                    nx.pressed = 1'b1;
                    nx.typed   = 1'b1;
                end
                else
                begin
                    nx.samples = inc;
                end
            end
            else
            begin
                nx.samples = '0;
                if (st.hold)
                begin
                    dly      = delay_step(st.phase, rep_lim);
                    nx.delay = dly;
                    nx.phase = dly;
                    if (dly == '0)
                    begin
                        nx.typed = 1'b1;
                    end
                end
                else
                begin
                    dly      = delay_step(st.phase, hold_lim);
                    nx.delay = dly;
                    nx.phase = dly;
                    if (dly == '0)
                    begin
                        nx.hold = 1'b1;
                    end
                end
            end
        end
        else if (st.pressed)
        begin
            if ($signed(dec) <= $signed(RELEASE_AT))
            begin
                nx = '0;
            end
            else
            begin
                nx.samples = dec;
            end
        end
        else
        begin
            nx.samples = '0;
        end
        return nx;
    endfunction

endpackage

### rtl/matrix_keypad_scanner_unit.sv
// matrix_keypad_scanner_unit: top level, config registers, input and result registers
// depends on kps_pkg, kps_delay_norm, kps_key_array
//
//   channel  | valid         | stall         | payload
//   ---------+---------------+---------------+-----------------------------
//   scan     | scan_valid    | scan_stall    | scan_beat   (kps_in_t)
//   result   | result_valid  | result_stall  | result_beat (kps_out_t)
//   config   | cfg_write     | -             | cfg_index, cfg_data
//
// one beat per cycle sustained while neither result_stall nor a rescaling pass holds the flow;
// a taken beat goes into the input register, then its key update into the result register
// reset clears all key state and the row pointer and loads the config reset values
// a write to hold_visits or repeat_visits runs a delay rescaling pass
// (16 remainder steps, one write-back) with scan_stall high
// a stalled result holds in its register while one more beat waits in the input register
module matrix_keypad_scanner_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         scan_valid,
    output logic                         scan_stall,
    input  kps_pkg::kps_in_t             scan_beat,
    output logic                         result_valid,
    input  logic                         result_stall,
    output kps_pkg::kps_out_t            result_beat,
    input  logic                         cfg_write,
    input  logic [1:0]                   cfg_index,
    input  logic [kps_pkg::DELAY_W-1:0]  cfg_data
);

    kps_pkg::kps_cfg_t       cfg_reg, cfg_next;
    kps_pkg::kps_in_t        beat_reg;
    logic                    beat_valid_reg, beat_valid_next;
    kps_pkg::kps_out_t       result_reg;
    logic                    result_valid_reg, result_valid_next;
    kps_pkg::kps_out_t       result_comb;
    kps_pkg::kps_norm_stat_t norm_stat;

    logic [kps_pkg::NKEYS-1:0]                        hold_vec;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0]  delay_vec;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0]  rem_vec;

    logic advance;
    logic take;
    logic norm_start;

    assign advance    = beat_valid_reg && !norm_stat.busy && (!result_valid_reg || !result_stall);
    assign scan_stall = norm_stat.busy || (beat_valid_reg && !advance);
    assign take       = scan_valid && !scan_stall;
    assign norm_start = cfg_write && ((cfg_index == kps_pkg::REG_HOLD_VISITS) ||
                                      (cfg_index == kps_pkg::REG_REPEAT_VISITS));

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                kps_pkg::REG_HOLD_VISITS:   cfg_next.hold_visits   = cfg_data;
                kps_pkg::REG_REPEAT_VISITS: cfg_next.repeat_visits = cfg_data;
                kps_pkg::REG_ACTIVE_LEVEL:  cfg_next.active_level  = cfg_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
        beat_valid_next   = take || (beat_valid_reg && !advance);
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_visits   <= kps_pkg::HOLD_VISITS_RESET;
            cfg_reg.repeat_visits <= kps_pkg::REPEAT_VISITS_RESET;
            cfg_reg.active_level  <= 1'b0;
            beat_valid_reg        <= 1'b0;
            result_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg          <= cfg_next;
            beat_valid_reg   <= beat_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= scan_beat;
        end
        if (advance)
        begin
            result_reg <= result_comb;
        end
    end

    kps_delay_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (norm_start),
        .cfg       (cfg_next),
        .hold_vec  (hold_vec),
        .delay_vec (delay_vec),
        .stat      (norm_stat),
        .rem_vec   (rem_vec)
    );

    kps_key_array u_keys
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .beat      (beat_reg),
        .cfg       (cfg_reg),
        .norm      (norm_stat),
        .rem_vec   (rem_vec),
        .result    (result_comb),
        .hold_vec  (hold_vec),
        .delay_vec (delay_vec)
    );

    assign result_valid = result_valid_reg;
    assign result_beat  = result_reg;

    a_no_update_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        norm_stat.busy |-> !advance)
        else $error("key update during rescaling pass");

    a_limit_write_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        norm_start |=> scan_stall)
        else $error("beat taken right after limit write");

endmodule

### rtl/kps_delay_norm.sv
// kps_delay_norm: reduces every key's delay count modulo its current limit after a limit write
// one restoring remainder step per lane and cycle; depends on kps_pkg
module kps_delay_norm
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  kps_pkg::kps_cfg_t                     cfg,
    input  logic [kps_pkg::NKEYS-1:0]             hold_vec,
    input  logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] delay_vec,
    output kps_pkg::kps_norm_stat_t               stat,
    output logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] rem_vec
);

    logic                        busy_reg, busy_next;
    logic                        finish_reg, finish_next;
    logic [kps_pkg::STEP_W-1:0]  step_reg, step_next;

    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] quo_reg, quo_next;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] rem_reg, rem_next;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W:0]   trial;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W:0]   modulus;
    logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W:0]   diff;

    always_comb
    begin
        busy_next   = busy_reg;
        finish_next = 1'b0;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        for (int k = 0; k < kps_pkg::NKEYS; k++)
        begin
            modulus[k] = kps_pkg::limit_ext(hold_vec[k] ? cfg.repeat_visits : cfg.hold_visits);
            trial[k]   = {rem_reg[k], quo_reg[k][kps_pkg::DELAY_W-1]};
            diff[k]    = trial[k] - modulus[k];
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = delay_vec;
            rem_next  = '0;
        end
        else if (finish_reg)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < kps_pkg::NKEYS; k++)
            begin
                quo_next[k] = {quo_reg[k][kps_pkg::DELAY_W-2:0], 1'b0};
                rem_next[k] = (trial[k] >= modulus[k]) ? diff[k][kps_pkg::DELAY_W-1:0]
                                                       : trial[k][kps_pkg::DELAY_W-1:0];
            end
            step_next = step_reg + kps_pkg::STEP_W'(1);
            if (step_reg == kps_pkg::STEP_W'(kps_pkg::DELAY_W - 1))
            begin
                finish_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            finish_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            finish_reg <= finish_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign stat.busy   = busy_reg;
    assign stat.finish = finish_reg;
    assign rem_vec     = rem_reg;

    a_finish_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        finish_reg |-> busy_reg)
        else $error("norm finish outside pass");

endmodule

### rtl/kps_key_array.sv
// kps_key_array: per-key debounce and repeat state, row pointer and result forming
// one update per beat for all keys of the scanned row in parallel; depends on kps_pkg
module kps_key_array
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  advance,
    input  kps_pkg::kps_in_t                      beat,
    input  kps_pkg::kps_cfg_t                     cfg,
    input  kps_pkg::kps_norm_stat_t               norm,
    input  logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] rem_vec,
    output kps_pkg::kps_out_t                     result,
    output logic [kps_pkg::NKEYS-1:0]             hold_vec,
    output logic [kps_pkg::NKEYS-1:0][kps_pkg::DELAY_W-1:0] delay_vec
);

    kps_pkg::key_state_t key_reg  [kps_pkg::ROWS][kps_pkg::COLUMNS];
    kps_pkg::key_state_t key_next [kps_pkg::ROWS][kps_pkg::COLUMNS];
    logic [kps_pkg::ROW_W-1:0] row_ptr_reg, row_ptr_next;

    logic                         is_scan;
    logic                         is_query;
    logic [kps_pkg::COLUMNS-1:0]  closed;
    logic [kps_pkg::NKEYS-1:0]    pressed_vec;
    logic [kps_pkg::NKEYS-1:0]    typed_vec;

    assign is_scan  = (beat.func == kps_pkg::FUNC_SCAN);
    assign is_query = (beat.func == kps_pkg::FUNC_QUERY);

    always_comb
    begin
        for (int c = 0; c < kps_pkg::COLUMNS; c++)
        begin
            // missing sense bits read as level 0
            if (c < kps_pkg::SENSE_BITS)
            begin
                closed[c] = (beat.column_sense[c] == cfg.active_level);
            end
            else
            begin
                closed[c] = (1'b0 == cfg.active_level);
            end
        end
    end

    always_comb
    begin
        result       = '0;
        row_ptr_next = row_ptr_reg;
        for (int r = 0; r < kps_pkg::ROWS; r++)
        begin
            for (int c = 0; c < kps_pkg::COLUMNS; c++)
            begin
                key_next[r][c] = key_reg[r][c];
                if (is_scan && (int'(row_ptr_reg) == r))
                begin
                    key_next[r][c] = kps_pkg::key_step(key_reg[r][c], closed[c],
                                                       cfg.hold_visits, cfg.repeat_visits);
                    if (c < kps_pkg::SENSE_BITS)
                    begin
                        result.pressed_mask[c] = key_next[r][c].pressed;
                    end
                end
                if (is_query && (int'(beat.key_row) == r) && (int'(beat.key_col) == c))
                begin
                    result.key_pressed   = key_reg[r][c].pressed;
                    result.key_typed     = key_reg[r][c].typed;
                    key_next[r][c].typed = 1'b0;
                end
            end
        end
        if (is_scan)
        begin
            result.scanned_row = 2'(row_ptr_reg);
            row_ptr_next = (int'(row_ptr_reg) == kps_pkg::ROWS - 1) ? '0
                         : row_ptr_reg + kps_pkg::ROW_W'(1);
        end
    end

    always_comb
    begin
        for (int r = 0; r < kps_pkg::ROWS; r++)
        begin
            for (int c = 0; c < kps_pkg::COLUMNS; c++)
            begin
                hold_vec[r*kps_pkg::COLUMNS + c]    = key_reg[r][c].hold;
                delay_vec[r*kps_pkg::COLUMNS + c]   = key_reg[r][c].delay;
                pressed_vec[r*kps_pkg::COLUMNS + c] = key_reg[r][c].pressed;
                typed_vec[r*kps_pkg::COLUMNS + c]   = key_reg[r][c].typed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_ptr_reg <= '0;
            for (int r = 0; r < kps_pkg::ROWS; r++)
            begin
                for (int c = 0; c < kps_pkg::COLUMNS; c++)
                begin
                    key_reg[r][c] <= '0;
                end
            end
        end
        else if (norm.finish)
        begin
            for (int r = 0; r < kps_pkg::ROWS; r++)
            begin
                for (int c = 0; c < kps_pkg::COLUMNS; c++)
                begin
                    key_reg[r][c].phase <= rem_vec[r*kps_pkg::COLUMNS + c];
                end
            end
        end
        else if (advance)
        begin
            row_ptr_reg <= row_ptr_next;
            for (int r = 0; r < kps_pkg::ROWS; r++)
            begin
                for (int c = 0; c < kps_pkg::COLUMNS; c++)
                begin
                    key_reg[r][c] <= key_next[r][c];
                end
            end
        end
    end

    a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (hold_vec & ~pressed_vec) == '0)
        else $error("hold flag on released key");

    a_typed_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        (typed_vec & ~pressed_vec) == '0)
        else $error("typed flag on released key");

    a_row_moves_on_scan: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && is_scan) |=> $stable(row_ptr_reg))
        else $error("row pointer moved without scan");

endmodule
